// ===== rtl/tgc_pkg.sv =====
package tgc_pkg;

    // Configuration register indexes, in the order of the register map.
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESS_THRESHOLD = 2'd0,
        REG_WINDOW_TICKS    = 2'd1,
        REG_POLL_INTERVAL   = 2'd2,
        REG_HOLDOFF_TICKS   = 2'd3
    } cfg_idx_t;

    localparam logic [3:0] WINDOW_RESET  = 4'd5;
    localparam logic [5:0] POLL_RESET    = 6'd6;
    localparam logic [3:0] HOLDOFF_RESET = 4'd2;

    // Timing registers that do not depend on the sample width.
    typedef struct packed {
        logic [3:0] window_ticks;
        logic [5:0] poll_interval;
        logic [3:0] holdoff_ticks;
    } cfg_t;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_HOLDOFF     = 3'd1,
        PH_FIRST_ONLY  = 3'd2,
        PH_SECOND_ONLY = 3'd3,
        PH_FAR_EITHER  = 3'd4,
        PH_LAST        = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        G_NONE        = 3'd0,
        G_LEFT_PUSH   = 3'd1,
        G_RIGHT_PUSH  = 3'd2,
        G_LEFT_SWIPE  = 3'd3,
        G_RIGHT_SWIPE = 3'd4
    } gesture_t;

endpackage

// ===== rtl/tgc_sample_if.sv =====
interface tgc_sample_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [3:0]             touch;
    logic [SAMPLE_BITS-1:0] pressure;

    modport source (output valid, output touch, output pressure, input ready);
    modport sink   (input valid, input touch, input pressure, output ready);
endinterface

// ===== rtl/tgc_result_if.sv =====
interface tgc_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] gesture;
    logic       failed;

    modport source (output valid, output gesture, output failed, input ready);
    modport sink   (input valid, input gesture, input failed, output ready);
endinterface

// ===== rtl/tgc_cfg_if.sv =====
interface tgc_cfg_if #(
    parameter int DATA_W = 12
);
    logic              valid;
    logic              ready;
    logic [1:0]        index;
    logic [DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tgc_cfg_regs.sv =====
module tgc_cfg_regs
    import tgc_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    tgc_cfg_if.sink                cfg,
    output logic [SAMPLE_BITS-1:0] press_threshold,
    output cfg_t                   timing
);

    // Eight percent of full scale, rounded to nearest.
    localparam int THRESH_RESET_INT = (8 * ((1 << SAMPLE_BITS) - 1) + 50) / 100;
    localparam logic [SAMPLE_BITS-1:0] THRESH_RESET = SAMPLE_BITS'(THRESH_RESET_INT);

    logic [SAMPLE_BITS-1:0] thresh_reg;
    cfg_t                   timing_reg;
    cfg_idx_t               idx;

    assign cfg.ready       = 1'b1;
    assign idx             = cfg_idx_t'(cfg.index);
    assign press_threshold = thresh_reg;
    assign timing          = timing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg               <= THRESH_RESET;
            timing_reg.window_ticks  <= WINDOW_RESET;
            timing_reg.poll_interval <= POLL_RESET;
            timing_reg.holdoff_ticks <= HOLDOFF_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (idx)
                REG_PRESS_THRESHOLD: thresh_reg               <= cfg.data;
                REG_WINDOW_TICKS:    timing_reg.window_ticks  <= cfg.data[3:0];
                REG_POLL_INTERVAL:   timing_reg.poll_interval <= cfg.data[5:0];
                REG_HOLDOFF_TICKS:   timing_reg.holdoff_ticks <= cfg.data[3:0];
                default:             thresh_reg               <= thresh_reg;
            endcase
        end
    end

endmodule

// ===== rtl/tgc_fsm.sv =====
module tgc_fsm
    import tgc_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [3:0]             touch,
    input  logic [SAMPLE_BITS-1:0] pressure,
    input  logic [SAMPLE_BITS-1:0] press_threshold,
    input  cfg_t                   timing,
    output gesture_t               gesture,
    output logic                   failed
);

    phase_t     phase_reg, phase_next;
    logic       left_reg, left_next;
    logic [3:0] win_reg, win_next;
    logic [5:0] poll_reg, poll_next;
    logic [3:0] hold_reg, hold_next;

    // Pads counted from the start side of a swipe.
    function automatic logic [3:0] mirror_pads(logic [3:0] t, logic rev);
        return rev ? {t[0], t[1], t[2], t[3]} : t;
    endfunction

    always_comb
    begin
        logic       left_only;
        logic       right_only;
        logic [3:0] pads;
        logic       do_miss;
        logic       do_decide;
        logic       done;

        phase_next = phase_reg;
        left_next  = left_reg;
        win_next   = win_reg;
        poll_next  = poll_reg;
        hold_next  = hold_reg;
        gesture    = G_NONE;
        failed     = 1'b0;
        do_miss    = 1'b0;
        do_decide  = 1'b0;
        done       = 1'b0;

        left_only  = (touch[1:0] != 2'b00) && (touch[3:2] == 2'b00);
        right_only = (touch[3:2] != 2'b00) && (touch[1:0] == 2'b00);
        pads       = mirror_pads(touch, left_reg);

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (poll_reg > 6'd1)
                begin
                    poll_next = poll_reg - 6'd1;
                end
                else
                begin
                    poll_next = timing.poll_interval;
                    if (pressure > press_threshold)
                    begin
                        if (left_only)
                            gesture = G_LEFT_PUSH;
                        else if (right_only)
                            gesture = G_RIGHT_PUSH;
                        else
                            failed = 1'b1;
                        do_decide = 1'b1;
                    end
                    else if (left_only || right_only)
                    begin
                        // A right-side touch swipes toward the left.
                        left_next = right_only;
                        pads      = mirror_pads(touch, right_only);
                        win_next  = timing.window_ticks;
                        if (pads[0] && pads[1])
                            phase_next = PH_FAR_EITHER;
                        else if (pads[0])
                            phase_next = PH_FIRST_ONLY;
                        else
                            phase_next = PH_SECOND_ONLY;
                    end
                end
            end
            PH_HOLDOFF:
            begin
                if (hold_reg > 4'd1)
                    hold_next = hold_reg - 4'd1;
                else
                begin
                    hold_next  = 4'd0;
                    phase_next = PH_IDLE;
                end
            end
            PH_FIRST_ONLY:
            begin
                if (pads[1])
                begin
                    phase_next = PH_FAR_EITHER;
                    win_next   = timing.window_ticks;
                end
                else if (pads[2])
                begin
                    phase_next = PH_LAST;
                    win_next   = timing.window_ticks;
                end
                else
                    do_miss = 1'b1;
            end
            PH_SECOND_ONLY:
            begin
                if (pads[2])
                begin
                    phase_next = PH_LAST;
                    win_next   = timing.window_ticks;
                end
                else
                    do_miss = 1'b1;
            end
            PH_FAR_EITHER:
            begin
                if (pads[2] || pads[3])
                    done = 1'b1;
                else
                    do_miss = 1'b1;
            end
            PH_LAST:
            begin
                if (pads[3])
                    done = 1'b1;
                else
                    do_miss = 1'b1;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // A missed sample counts the window down; a used-up window fails.
        if (do_miss)
        begin
            if (win_reg <= 4'd1)
            begin
                win_next  = 4'd0;
                failed    = 1'b1;
                do_decide = 1'b1;
            end
            else
                win_next = win_reg - 4'd1;
        end

        if (done)
        begin
            gesture   = left_reg ? G_LEFT_SWIPE : G_RIGHT_SWIPE;
            do_decide = 1'b1;
        end

        if (do_decide)
        begin
            if (timing.holdoff_ticks == 4'd0)
                phase_next = PH_IDLE;
            else
            begin
                phase_next = PH_HOLDOFF;
                hold_next  = timing.holdoff_ticks;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            left_reg  <= 1'b0;
            win_reg   <= 4'd0;
            poll_reg  <= POLL_RESET;
            hold_reg  <= 4'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            win_reg   <= win_next;
            poll_reg  <= poll_next;
            hold_reg  <= hold_next;
        end
    end

endmodule

// ===== rtl/touch_gesture_classifier_core.sv =====
// Touch gesture classifier: turns a stream of pad/pressure samples into push
// and swipe gestures.
// The sample channel carries one tick of sensor data per transfer: four pad
// touch bits (pad 0 leftmost) and a pressure reading of SAMPLE_BITS bits.
// Every accepted sample produces exactly one transfer on the result channel,
// holding the gesture code and a failure flag; both are zero when the sample
// brings no decision.
// The configuration channel writes the threshold and timing registers by
// index; it is always ready and is meant to be used while the block is idle.
// A sample is captured in an input register; when it advances, the gesture
// state machine updates and the result register loads in the same cycle, and
// the result is then offered. The block sustains one sample per cycle while the
// result receiver is ready; one state machine step per sample sets that rate.
// When the result receiver stalls, the result register holds and the input
// register still takes one more sample; after that the sample channel drops
// ready until the result moves on. No sample or result is lost or repeated.
// Reset empties both pipeline registers, returns the state machine to idle with
// the poll counter at its reset interval, and loads the register defaults.
module touch_gesture_classifier_core
    import tgc_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    tgc_sample_if.sink    sample,
    tgc_result_if.source  result,
    tgc_cfg_if.sink       cfg
);

    logic                   in_vld_reg;
    logic [3:0]             touch_reg;
    logic [SAMPLE_BITS-1:0] pressure_reg;

    logic                   out_vld_reg;
    logic [2:0]             gesture_reg;
    logic                   failed_reg;

    logic [SAMPLE_BITS-1:0] press_threshold;
    cfg_t                   timing;
    gesture_t               gesture_next;
    logic                   failed_next;
    logic                   advance;

    // The held sample moves into the result register whenever that register
    // is empty or its result is being transferred out in this cycle.
    assign advance      = in_vld_reg && (!out_vld_reg || result.ready);
    assign sample.ready = !in_vld_reg || advance;

    assign result.valid   = out_vld_reg;
    assign result.gesture = gesture_reg;
    assign result.failed  = failed_reg;

    tgc_cfg_regs #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cfg_regs (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .press_threshold (press_threshold),
        .timing          (timing)
    );

    tgc_fsm #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_fsm (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (advance),
        .touch           (touch_reg),
        .pressure        (pressure_reg),
        .press_threshold (press_threshold),
        .timing          (timing),
        .gesture         (gesture_next),
        .failed          (failed_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
                in_vld_reg <= sample.valid;
            if (advance)
                out_vld_reg <= 1'b1;
            else if (result.ready)
                out_vld_reg <= 1'b0;
        end
    end

    // Payload registers carry no reset; the valid bits qualify them.
    always_ff @(posedge clk)
    begin
        if (sample.ready && sample.valid)
        begin
            touch_reg    <= sample.touch;
            pressure_reg <= sample.pressure;
        end
        if (advance)
        begin
            gesture_reg <= gesture_next;
            failed_reg  <= failed_next;
        end
    end

endmodule

// ===== tb/tb_touch_gesture_classifier_core.sv =====
module tb_touch_gesture_classifier_core
    import tgc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_BITS = 12;
    localparam int FULL_SCALE = (1 << SAMPLE_BITS) - 1;
    localparam int PHASE_ITEMS = 305;
    localparam int LONG_STALL_CYCLES = 80;

    // One result transfer: the gesture code and the failure flag.
    typedef struct packed {
        gesture_t gesture;
        logic     failed;
    } verdict_t;

    // A row of the opening table is either a register write or a sample.
    // Samples with check set carry an expectation typed in by hand; all other
    // samples are checked against the gesture predictor below.
    typedef enum bit {
        ROW_SAMPLE = 1'b0,
        ROW_CFG    = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        cfg_idx_t               reg_idx;
        logic [SAMPLE_BITS-1:0] reg_val;
        logic [3:0]             touch;
        logic [SAMPLE_BITS-1:0] pressure;
        bit                     check;
        gesture_t               gesture;
        logic                   failed;
    } row_t;

    localparam int N_ROWS = 32;

    // The opening sequence. Right after reset the poll counter still holds its
    // reset interval, so the first five samples are idle ticks no matter what
    // they carry. With the poll interval at one and no holdoff, every later
    // idle sample is a poll instant, which keeps the pushes and swipes short.
    localparam row_t DIRECTED_ROWS [N_ROWS] = '{
        '{ROW_CFG,    REG_POLL_INTERVAL,   12'd1,    4'h0,    12'd0,    1'b0, G_NONE, 1'b0},
        '{ROW_CFG,    REG_HOLDOFF_TICKS,   12'd0,    4'h0,    12'd0,    1'b0, G_NONE, 1'b0},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'hf,    12'd4095, 1'b1, G_NONE, 1'b0},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'hf,    12'd4095, 1'b1, G_NONE, 1'b0},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'hf,    12'd4095, 1'b1, G_NONE, 1'b0},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'hf,    12'd4095, 1'b1, G_NONE, 1'b0},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'hf,    12'd4095, 1'b1, G_NONE, 1'b0},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'b0001, 12'd4095, 1'b1, G_LEFT_PUSH, 1'b0},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'b1000, 12'd4095, 1'b1, G_RIGHT_PUSH, 1'b0},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'b1001, 12'd4095, 1'b1, G_NONE, 1'b1},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'b0000, 12'd4095, 1'b1, G_NONE, 1'b1},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'b0000, 12'd328,  1'b1, G_NONE, 1'b0},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'b0001, 12'd328,  1'b0, G_NONE, 1'b0},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'b0010, 12'd0,    1'b0, G_NONE, 1'b0},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'b1000, 12'd0,    1'b0, G_NONE, 1'b0},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'b1100, 12'd0,    1'b0, G_NONE, 1'b0},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'b0010, 12'd0,    1'b0, G_NONE, 1'b0},
        '{ROW_CFG,    REG_WINDOW_TICKS,    12'd0,    4'h0,    12'd0,    1'b0, G_NONE, 1'b0},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'b0010, 12'd0,    1'b0, G_NONE, 1'b0},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'b0000, 12'd0,    1'b0, G_NONE, 1'b0},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'b0001, 12'd0,    1'b0, G_NONE, 1'b0},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'b0100, 12'd0,    1'b0, G_NONE, 1'b0},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'b1000, 12'd0,    1'b0, G_NONE, 1'b0},
        '{ROW_CFG,    REG_PRESS_THRESHOLD, 12'd4095, 4'h0,    12'd0,    1'b0, G_NONE, 1'b0},
        '{ROW_CFG,    REG_WINDOW_TICKS,    12'd15,   4'h0,    12'd0,    1'b0, G_NONE, 1'b0},
        '{ROW_CFG,    REG_HOLDOFF_TICKS,   12'd15,   4'h0,    12'd0,    1'b0, G_NONE, 1'b0},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'b0011, 12'd4095, 1'b0, G_NONE, 1'b0},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'b0000, 12'd0,    1'b0, G_NONE, 1'b0},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'b0100, 12'd0,    1'b0, G_NONE, 1'b0},
        '{ROW_SAMPLE, REG_PRESS_THRESHOLD, 12'd0,    4'b1111, 12'd4095, 1'b1, G_NONE, 1'b0},
        '{ROW_CFG,    REG_PRESS_THRESHOLD, 12'd0,    4'h0,    12'd0,    1'b0, G_NONE, 1'b0},
        '{ROW_CFG,    REG_POLL_INTERVAL,   12'd63,   4'h0,    12'd0,    1'b0, G_NONE, 1'b0}
    };

    logic clk;
    logic rst_n;

    tgc_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_bus ();
    tgc_result_if                              result_bus ();
    tgc_cfg_if    #(.DATA_W(SAMPLE_BITS))      cfg_bus ();

    touch_gesture_classifier_core #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // Register copies that the predictor works from, at the block's widths.
    logic [SAMPLE_BITS-1:0] thresh_reg;
    logic [3:0]             window_reg;
    logic [5:0]             poll_reg;
    logic [3:0]             holdoff_reg;

    // Gesture state as the predictor tracks it.
    phase_t     gest_phase;
    logic       toward_left;
    logic [3:0] window_count;
    logic [5:0] poll_count;
    logic [3:0] holdoff_count;

    // Results still owed by the block, oldest first.
    verdict_t expected_verdicts[$];

    int src_idle_pct;
    int snk_idle_pct;
    int stall_requests;
    int stalls_served;
    int stall_left;

    int errors;
    int samples_sent;
    int results_checked;
    int push_count;
    int swipe_count;
    int fail_count;

    // Free-running clock, 10 ns period.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Mirror image of the pad bits: pad p becomes pad 3-p.
    function automatic logic [3:0] mirror_pads(logic [3:0] t);
        return {t[0], t[1], t[2], t[3]};
    endfunction

    // Pad bits counted from the side where the current swipe started.
    function automatic logic [3:0] swipe_view(logic [3:0] t);
        return toward_left ? mirror_pads(t) : t;
    endfunction

    // A decision or a failure: either straight back to idle or into holdoff.
    function automatic void settle();
        if (holdoff_reg == 4'd0) begin
            gest_phase = PH_IDLE;
        end else begin
            gest_phase    = PH_HOLDOFF;
            holdoff_count = holdoff_reg;
        end
    endfunction

    function automatic void open_wait(phase_t next);
        gest_phase   = next;
        window_count = window_reg;
    endfunction

    // A sample that misses in a wait stage. A zero window behaves as one,
    // since the wait gives up once at most one tick is left.
    function automatic bit window_miss();
        if (window_count <= 4'd1) begin
            window_count = 4'd0;
            settle();
            return 1'b1;
        end
        window_count = window_count - 4'd1;
        return 1'b0;
    endfunction

    // Gesture predictor: advances the tracked state by one sample and returns
    // the result that the sample must cause.
    function automatic verdict_t classify_sample(logic [3:0] t, logic [SAMPLE_BITS-1:0] p);
        verdict_t   v;
        logic       left_only;
        logic       right_only;
        logic       done;
        logic [3:0] rel;

        v.gesture  = G_NONE;
        v.failed   = 1'b0;
        done       = 1'b0;
        left_only  = (t[1:0] != 2'b00) && (t[3:2] == 2'b00);
        right_only = (t[3:2] != 2'b00) && (t[1:0] == 2'b00);
        rel        = swipe_view(t);

        case (gest_phase)
            PH_IDLE: begin
                // The poll counter only runs while idle; a zero interval
                // makes every idle sample a poll instant.
                if (poll_count > 6'd1) begin
                    poll_count = poll_count - 6'd1;
                end else begin
                    poll_count = poll_reg;
                    if (p > thresh_reg) begin
                        if (left_only) begin
                            v.gesture = G_LEFT_PUSH;
                        end else if (right_only) begin
                            v.gesture = G_RIGHT_PUSH;
                        end else begin
                            v.failed = 1'b1;
                        end
                        settle();
                    end else if (left_only || right_only) begin
                        // A touch on the right side starts a swipe toward
                        // the left, and the other way round.
                        toward_left = right_only;
                        rel         = swipe_view(t);
                        if (rel[0] && rel[1]) begin
                            open_wait(PH_FAR_EITHER);
                        end else if (rel[0]) begin
                            open_wait(PH_FIRST_ONLY);
                        end else begin
                            open_wait(PH_SECOND_ONLY);
                        end
                    end
                end
            end
            PH_HOLDOFF: begin
                if (holdoff_count > 4'd0) begin
                    holdoff_count = holdoff_count - 4'd1;
                end
                if (holdoff_count == 4'd0) begin
                    gest_phase = PH_IDLE;
                end
            end
            PH_FIRST_ONLY: begin
                // The second pad wins over the third when both are touched.
                if (rel[1]) begin
                    open_wait(PH_FAR_EITHER);
                end else if (rel[2]) begin
                    open_wait(PH_LAST);
                end else if (window_miss()) begin
                    v.failed = 1'b1;
                end
            end
            PH_SECOND_ONLY: begin
                if (rel[2]) begin
                    open_wait(PH_LAST);
                end else if (window_miss()) begin
                    v.failed = 1'b1;
                end
            end
            PH_FAR_EITHER: begin
                if (rel[2] || rel[3]) begin
                    done = 1'b1;
                end else if (window_miss()) begin
                    v.failed = 1'b1;
                end
            end
            PH_LAST: begin
                if (rel[3]) begin
                    done = 1'b1;
                end else if (window_miss()) begin
                    v.failed = 1'b1;
                end
            end
            default: begin
                gest_phase = PH_IDLE;
            end
        endcase

        if (done) begin
            v.gesture = toward_left ? G_LEFT_SWIPE : G_RIGHT_SWIPE;
            settle();
        end
        return v;
    endfunction

    // Chooses the next random sample from the tracked state, so that most
    // samples continue a well-formed push or swipe and the rest are misses,
    // wrong pads and plain noise.
    task automatic pick_sample(output logic [3:0] t, output logic [SAMPLE_BITS-1:0] p);
        int         roll;
        bit         hit;
        int         low_p;
        int         high_p;
        logic [3:0] rel;

        roll   = $urandom_range(0, 99);
        hit    = ($urandom_range(0, 99) < 65);
        low_p  = $urandom_range(0, int'(thresh_reg));
        high_p = (int'(thresh_reg) >= FULL_SCALE) ? FULL_SCALE :
                 $urandom_range(int'(thresh_reg) + 1, FULL_SCALE);
        t      = 4'($urandom);
        p      = SAMPLE_BITS'($urandom);

        if (roll >= 15) begin
            case (gest_phase)
                PH_IDLE: begin
                    if (roll < 40) begin
                        // Strong press on one side, both sides or none.
                        case ($urandom_range(0, 3))
                            0: t = {2'b00, 2'($urandom_range(1, 3))};
                            1: t = {2'($urandom_range(1, 3)), 2'b00};
                            2: t = 4'($urandom);
                            default: t = 4'b0000;
                        endcase
                        p = SAMPLE_BITS'(high_p);
                    end else begin
                        case ($urandom_range(0, 2))
                            0: rel = 4'b0001;
                            1: rel = 4'b0011;
                            default: rel = 4'b0010;
                        endcase
                        t = $urandom_range(0, 1) ? mirror_pads(rel) : rel;
                        p = SAMPLE_BITS'(low_p);
                    end
                end
                PH_FIRST_ONLY: begin
                    if (hit) begin
                        rel = $urandom_range(0, 1) ? 4'b0010 : 4'b0100;
                    end else begin
                        rel = $urandom_range(0, 1) ? 4'b0000 : 4'b0001;
                    end
                    t = swipe_view(rel);
                end
                PH_SECOND_ONLY: begin
                    if (hit) begin
                        rel = 4'b0100;
                    end else begin
                        rel = $urandom_range(0, 1) ? 4'b0000 : 4'b1000;
                    end
                    t = swipe_view(rel);
                end
                PH_FAR_EITHER: begin
                    if (hit) begin
                        case ($urandom_range(0, 2))
                            0: rel = 4'b0100;
                            1: rel = 4'b1000;
                            default: rel = 4'b1100;
                        endcase
                    end else begin
                        rel = $urandom_range(0, 1) ? 4'b0000 : 4'b0011;
                    end
                    t = swipe_view(rel);
                end
                PH_LAST: begin
                    if (hit) begin
                        rel = 4'b1000;
                    end else begin
                        rel = $urandom_range(0, 1) ? 4'b0000 : 4'b0100;
                    end
                    t = swipe_view(rel);
                end
                default: begin
                    // Holdoff samples are ignored; keep the random content.
                end
            endcase
        end
    endtask

    // Offers one sample on the sample channel, after random idle cycles as
    // the current sender idle rate asks. Valid stays high from one sample to
    // the next unless an idle cycle falls in between. When the transfer takes
    // place the predictor steps, and the owed result is queued: the typed-in
    // one for checked table rows, the predicted one otherwise.
    task automatic send_sample(input logic [3:0] t, input logic [SAMPLE_BITS-1:0] p,
                               input bit typed, input verdict_t typed_v);
        verdict_t v;

        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            sample_bus.valid = 1'b0;
            @(negedge clk);
        end
        sample_bus.valid    = 1'b1;
        sample_bus.touch    = t;
        sample_bus.pressure = p;
        do begin
            @(posedge clk);
        end while (!sample_bus.ready);
        v = classify_sample(t, p);
        expected_verdicts.push_back(typed ? typed_v : v);
        samples_sent++;
    endtask

    // Waits until every owed result has come back, then a few more cycles so
    // that the block is settled in its idle state.
    task automatic wait_drained();
        while (expected_verdicts.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // One register write on the configuration channel, issued only once the
    // block has drained. The sample channel goes quiet first, so that the
    // last sample is not offered again while the block drains. The predictor's
    // copy takes the value at the transfer.
    task automatic write_reg(input cfg_idx_t idx, input logic [SAMPLE_BITS-1:0] val);
        @(negedge clk);
        sample_bus.valid = 1'b0;
        wait_drained();
        @(negedge clk);
        cfg_bus.valid    = 1'b1;
        cfg_bus.index    = idx;
        cfg_bus.data     = val;
        do begin
            @(posedge clk);
        end while (!cfg_bus.ready);
        case (idx)
            REG_PRESS_THRESHOLD: thresh_reg  = val;
            REG_WINDOW_TICKS:    window_reg  = val[3:0];
            REG_POLL_INTERVAL:   poll_reg    = val[5:0];
            REG_HOLDOFF_TICKS:   holdoff_reg = val[3:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // Result receiver. Ready changes at the falling edge only. A long stall,
    // once asked for, is counted out here in cycles while the sender keeps
    // offering samples, so the block fills up and drops its input ready.
    always @(negedge clk) begin
        if (stalls_served != stall_requests) begin
            stalls_served++;
            stall_left = LONG_STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            result_bus.ready = 1'b0;
        end else begin
            result_bus.ready = ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Result checker: every result transfer is matched, field by field,
    // against the oldest owed result.
    always @(posedge clk) begin
        verdict_t want;
        if (rst_n && result_bus.valid && result_bus.ready) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual gesture %0d failed %0d",
                         $time, result_bus.gesture, result_bus.failed);
                errors++;
            end else begin
                want = expected_verdicts.pop_front();
                results_checked++;
                if (result_bus.gesture !== want.gesture) begin
                    $display("%0t: gesture mismatch, expected %0d, actual %0d",
                             $time, want.gesture, result_bus.gesture);
                    errors++;
                end
                if (result_bus.failed !== want.failed) begin
                    $display("%0t: failed flag mismatch, expected %0d, actual %0d",
                             $time, want.failed, result_bus.failed);
                    errors++;
                end
                if (want.gesture == G_LEFT_PUSH || want.gesture == G_RIGHT_PUSH) begin
                    push_count++;
                end
                if (want.gesture == G_LEFT_SWIPE || want.gesture == G_RIGHT_SWIPE) begin
                    swipe_count++;
                end
                if (want.failed) begin
                    fail_count++;
                end
            end
        end
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [3:0]             t;
        logic [SAMPLE_BITS-1:0] p;
        verdict_t               typed_v;
        int                     seg;

        // All block inputs are known from time zero, reset held low.
        rst_n               = 1'b0;
        sample_bus.valid    = 1'b0;
        sample_bus.touch    = 4'h0;
        sample_bus.pressure = '0;
        result_bus.ready    = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = REG_PRESS_THRESHOLD;
        cfg_bus.data        = '0;
        src_idle_pct        = 36;
        snk_idle_pct        = 87;
        stall_requests      = 0;
        stalls_served       = 0;
        stall_left          = 0;
        errors              = 0;
        samples_sent        = 0;
        results_checked     = 0;
        push_count          = 0;
        swipe_count         = 0;
        fail_count          = 0;

        // Predictor state after reset: defaults loaded, idle, poll counter
        // at the reset interval.
        thresh_reg    = SAMPLE_BITS'((8 * FULL_SCALE + 50) / 100);
        window_reg    = WINDOW_RESET;
        poll_reg      = POLL_RESET;
        holdoff_reg   = HOLDOFF_RESET;
        gest_phase    = PH_IDLE;
        toward_left   = 1'b0;
        window_count  = 4'd0;
        poll_count    = POLL_RESET;
        holdoff_count = 4'd0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Opening table: pushes, failures, both swipe directions, every wait
        // stage, the zero window and the register extremes.
        for (int i = 0; i < N_ROWS; i++) begin
            if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
                write_reg(DIRECTED_ROWS[i].reg_idx, DIRECTED_ROWS[i].reg_val);
            end else begin
                typed_v.gesture = DIRECTED_ROWS[i].gesture;
                typed_v.failed  = DIRECTED_ROWS[i].failed;
                send_sample(DIRECTED_ROWS[i].touch, DIRECTED_ROWS[i].pressure,
                            DIRECTED_ROWS[i].check, typed_v);
            end
        end

        // Random phases. Idling cycles through a slow receiver, a slow sender
        // and no idling at all; each phase runs under its own register set,
        // the extremes among them. The phases without idling also carry one
        // long receiver stall.
        for (seg = 0; seg < 6; seg++) begin
            case (seg)
                0: begin
                    write_reg(REG_PRESS_THRESHOLD, 12'd328);
                    write_reg(REG_WINDOW_TICKS, 12'd5);
                    write_reg(REG_POLL_INTERVAL, 12'd6);
                    write_reg(REG_HOLDOFF_TICKS, 12'd2);
                end
                1: begin
                    write_reg(REG_PRESS_THRESHOLD, 12'd0);
                    write_reg(REG_WINDOW_TICKS, 12'd15);
                    write_reg(REG_POLL_INTERVAL, 12'd1);
                    write_reg(REG_HOLDOFF_TICKS, 12'd0);
                end
                4: begin
                    write_reg(REG_PRESS_THRESHOLD, 12'd4095);
                    write_reg(REG_WINDOW_TICKS, 12'd1);
                    write_reg(REG_POLL_INTERVAL, 12'd63);
                    write_reg(REG_HOLDOFF_TICKS, 12'd15);
                end
                5: begin
                    write_reg(REG_PRESS_THRESHOLD, 12'd2048);
                    write_reg(REG_WINDOW_TICKS, 12'd0);
                    write_reg(REG_POLL_INTERVAL, 12'd0);
                    write_reg(REG_HOLDOFF_TICKS, 12'd0);
                end
                default: begin
                    write_reg(REG_PRESS_THRESHOLD, SAMPLE_BITS'($urandom_range(0, FULL_SCALE)));
                    write_reg(REG_WINDOW_TICKS, SAMPLE_BITS'($urandom_range(0, 15)));
                    write_reg(REG_POLL_INTERVAL, SAMPLE_BITS'($urandom_range(0, 12)));
                    write_reg(REG_HOLDOFF_TICKS, SAMPLE_BITS'($urandom_range(0, 15)));
                end
            endcase

            case (seg % 3)
                0: begin
                    src_idle_pct = 36;
                    snk_idle_pct = 87;
                end
                1: begin
                    src_idle_pct = 87;
                    snk_idle_pct = 36;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (seg % 3 == 2 && n == PHASE_ITEMS / 3) begin
                    stall_requests++;
                end
                pick_sample(t, p);
                send_sample(t, p, 1'b0, typed_v);
            end
        end

        @(negedge clk);
        sample_bus.valid = 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);

        $display("covered %0d samples over an opening table and six register sets,",
                 samples_sent);
        $display("%0d results checked: %0d pushes, %0d swipes, %0d failures",
                 results_checked, push_count, swipe_count, fail_count);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
